@@ rtl/dqrs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and step functions for the dual quadrature rack sync core.
// No dependencies; used by every module in rtl/.
package dqrs_pkg;

  localparam int CNT_W     = 32;
  localparam int OUT_W     = 32;
  localparam int THR_W     = 8;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;
  localparam int Q_DEPTH   = 3;
  localparam int Q_IDX_W   = $clog2(Q_DEPTH);
  localparam int Q_LVL_W   = $clog2(Q_DEPTH + 1);

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(3);

  localparam logic [CFG_IDX_W-1:0] REG_RACK_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_NEGATE   = CFG_IDX_W'(1);

  localparam logic ACT_PIN_SAMPLE = 1'b0;
  localparam logic ACT_TICK       = 1'b1;

  localparam logic [1:0] PH_00 = 2'b00;
  localparam logic [1:0] PH_01 = 2'b01;
  localparam logic [1:0] PH_11 = 2'b11;
  localparam logic [1:0] PH_10 = 2'b10;

  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic signed [OUT_W-1:0] out_word_t;

  typedef struct packed {
    logic action;
    logic left_a;
    logic left_b;
    logic right_a;
    logic right_b;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] left_position;
    logic signed [OUT_W-1:0] right_position;
    logic signed [OUT_W-1:0] rack_delta;
  } out_item_t;

  typedef struct packed {
    logic sample;
    logic tick;
    logic captured;
    logic negate;
  } lane_ctrl_t;

  typedef struct packed {
    cnt_t cur;
    cnt_t delta;
  } lane_res_t;

  function automatic logic [1:0] step_fwd(input logic [1:0] last);
    logic [1:0] nxt;
    unique case (last)
      PH_00:   nxt = PH_01;
      PH_01:   nxt = PH_11;
      PH_11:   nxt = PH_10;
      default: nxt = PH_00;
    endcase
    return nxt;
  endfunction

  function automatic logic [1:0] step_back(input logic [1:0] last);
    logic [1:0] nxt;
    unique case (last)
      PH_00:   nxt = PH_10;
      PH_01:   nxt = PH_00;
      PH_11:   nxt = PH_01;
      default: nxt = PH_11;
    endcase
    return nxt;
  endfunction

  function automatic out_word_t to_out(input cnt_t v);
    logic signed [CNT_W-1:0] s;
    s = v;
    return out_word_t'(s);
  endfunction

  function automatic cnt_t magnitude(input cnt_t v);
    return v[CNT_W-1] ? cnt_t'(-v) : v;
  endfunction

endpackage

@@ rtl/dqrs_lane.sv @@
`timescale 1ns / 1ps
// One quadrature decoder lane: x4 counter, pin state, tick delta register.
// Depends on dqrs_pkg.
module dqrs_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  dqrs_pkg::lane_ctrl_t ctrl,
  input  logic [1:0]          pins,
  output dqrs_pkg::lane_res_t res
);

  dqrs_pkg::cnt_t count_r, count_nxt;
  dqrs_pkg::cnt_t prev_r, prev_nxt;
  dqrs_pkg::cnt_t cur_r, delta_r;
  logic [1:0]     pin_r, pin_nxt;
  dqrs_pkg::cnt_t cur, delta;

  assign cur   = ctrl.negate ? dqrs_pkg::cnt_t'(-count_r) : count_r;
  assign delta = cur - prev_r;

  always_comb begin
    count_nxt = count_r;
    pin_nxt   = pin_r;
    prev_nxt  = prev_r;
    if (ctrl.sample) begin
      pin_nxt = pins;
      if (ctrl.captured) begin
        if (pins == dqrs_pkg::step_fwd(pin_r)) begin
          count_nxt = count_r + dqrs_pkg::cnt_t'(1);
        end else if (pins == dqrs_pkg::step_back(pin_r)) begin
          count_nxt = count_r - dqrs_pkg::cnt_t'(1);
        end
      end
    end
    if (ctrl.tick) begin
      prev_nxt = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pin_r   <= '0;
      prev_r  <= '0;
    end else begin
      count_r <= count_nxt;
      pin_r   <= pin_nxt;
      prev_r  <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.tick) begin
      cur_r   <= cur;
      delta_r <= delta;
    end
  end

  assign res.cur   = cur_r;
  assign res.delta = delta_r;

endmodule

@@ rtl/dqrs_merge.sv @@
`timescale 1ns / 1ps
// Side selection across both lanes and the result queue toward out_*.
// Depends on dqrs_pkg.
module dqrs_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  dqrs_pkg::lane_res_t           left,
  input  dqrs_pkg::lane_res_t           right,
  input  logic [dqrs_pkg::THR_W-1:0]    threshold,
  output logic [dqrs_pkg::Q_LVL_W-1:0]  level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dqrs_pkg::out_item_t           out_data
);

  dqrs_pkg::cnt_t      mag_l, mag_r, thr;
  dqrs_pkg::cnt_t      pos_l, pos_r, dsel;
  dqrs_pkg::out_item_t item;
  dqrs_pkg::out_item_t q_r [dqrs_pkg::Q_DEPTH];
  dqrs_pkg::out_item_t q_nxt [dqrs_pkg::Q_DEPTH];
  logic [dqrs_pkg::Q_LVL_W-1:0] level_r, level_nxt;
  logic [dqrs_pkg::Q_IDX_W-1:0] wr_idx;
  logic                         pop;

  assign mag_l = dqrs_pkg::magnitude(left.delta);
  assign mag_r = dqrs_pkg::magnitude(right.delta);
  assign thr   = dqrs_pkg::cnt_t'(threshold);

  always_comb begin
    pos_l = left.cur;
    pos_r = right.cur;
    dsel  = left.delta;
    if (mag_l > thr && mag_l >= mag_r) begin
      pos_r = left.cur;
    end else if (mag_r > thr && mag_r > mag_l) begin
      pos_l = right.cur;
      dsel  = right.delta;
    end
    item.left_position  = dqrs_pkg::to_out(pos_l);
    item.right_position = dqrs_pkg::to_out(pos_r);
    item.rack_delta     = dqrs_pkg::to_out(dsel);
  end

  assign out_valid = (level_r != '0);
  assign pop       = out_valid && !out_stall;
  assign wr_idx    = dqrs_pkg::Q_IDX_W'(level_r - dqrs_pkg::Q_LVL_W'(pop));

  always_comb begin
    level_nxt = level_r + dqrs_pkg::Q_LVL_W'(push) - dqrs_pkg::Q_LVL_W'(pop);
    for (int i = 0; i < dqrs_pkg::Q_DEPTH; i++) begin
      if (pop && i < dqrs_pkg::Q_DEPTH - 1) begin
        q_nxt[i] = q_r[i+1];
      end else begin
        q_nxt[i] = q_r[i];
      end
    end
    if (push) begin
      q_nxt[wr_idx] = item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else begin
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign level    = level_r;
  assign out_data = q_r[0];

endmodule

@@ rtl/dual_quadrature_rack_sync_core.sv @@
`timescale 1ns / 1ps
// Dual x4 quadrature decoder with rack side selection; top level.
// Depends on dqrs_pkg, dqrs_lane and dqrs_merge.
// A sample tick's result passes through the lane tick registers and the result queue before it is offered.
// Throughput: one item per cycle while in_stall is low; a three-entry result queue absorbs out_stall.
// Pin samples update the counters at transfer and produce no result.
// Synchronous reset clears counters, pin states, tick history and queue, and restores
// the register defaults.
module dual_quadrature_rack_sync_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dqrs_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dqrs_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dqrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dqrs_pkg::CFG_DAT_W-1:0]  cfg_data
);

  logic [dqrs_pkg::THR_W-1:0]   thr_r, thr_nxt;
  logic                         neg_r, neg_nxt;
  logic                         captured_r, captured_nxt;
  logic                         s1_valid_r;
  logic                         accept, tick_acc, sample_acc;
  logic [dqrs_pkg::Q_LVL_W-1:0] level;
  logic [dqrs_pkg::Q_LVL_W:0]   occupancy;
  dqrs_pkg::lane_ctrl_t         ctrl_l, ctrl_r;
  dqrs_pkg::lane_res_t          res_l, res_r;

  assign cfg_ready  = 1'b1;
  assign occupancy  = {1'b0, level} + (dqrs_pkg::Q_LVL_W + 1)'(s1_valid_r);
  assign in_stall   = (occupancy >= (dqrs_pkg::Q_LVL_W + 1)'(dqrs_pkg::Q_DEPTH));
  assign accept     = in_valid && !in_stall;
  assign tick_acc   = accept && (in_data.action == dqrs_pkg::ACT_TICK);
  assign sample_acc = accept && (in_data.action == dqrs_pkg::ACT_PIN_SAMPLE);

  always_comb begin
    thr_nxt = thr_r;
    neg_nxt = neg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dqrs_pkg::REG_RACK_THRESHOLD: thr_nxt = cfg_data[dqrs_pkg::THR_W-1:0];
        dqrs_pkg::REG_RIGHT_NEGATE:   neg_nxt = cfg_data[0];
        default: ;
      endcase
    end
    captured_nxt = captured_r || sample_acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= dqrs_pkg::THR_RESET;
      neg_r      <= 1'b1;
      captured_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      thr_r      <= thr_nxt;
      neg_r      <= neg_nxt;
      captured_r <= captured_nxt;
      s1_valid_r <= tick_acc;
    end
  end

  assign ctrl_l = '{sample: sample_acc, tick: tick_acc, captured: captured_r, negate: 1'b0};
  assign ctrl_r = '{sample: sample_acc, tick: tick_acc, captured: captured_r, negate: neg_r};

  dqrs_lane u_lane_left (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl_l),
    .pins  ({in_data.left_a, in_data.left_b}),
    .res   (res_l)
  );

  dqrs_lane u_lane_right (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl_r),
    .pins  ({in_data.right_a, in_data.right_b}),
    .res   (res_r)
  );

  dqrs_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r),
    .left      (res_l),
    .right     (res_r),
    .threshold (thr_r),
    .level     (level),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= (dqrs_pkg::Q_LVL_W + 1)'(dqrs_pkg::Q_DEPTH))
    else $error("result queue overrun");

  a_tick_enters: assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> s1_valid_r)
    else $error("tick transfer did not enter the selection stage");

  a_sample_silent: assert property (@(posedge clk) disable iff (!rst_n)
    sample_acc |=> !s1_valid_r)
    else $error("pin sample produced a result");

  a_captured_holds: assert property (@(posedge clk) disable iff (!rst_n)
    captured_r |=> captured_r)
    else $error("pin capture flag dropped without reset");

endmodule
